@@ rtl/core/ssas_pkg.sv @@
`timescale 1ns / 1ps

package ssas_pkg;

	// Field widths of the request, piece and configuration beats.
	localparam int POS_W     = 48;
	localparam int LEN_W     = 32;
	localparam int SEG_W     = 2;
	localparam int TYPE_W    = 3;
	localparam int CNT_W     = 3;
	localparam int CFG_IDX_W = 3;

	// Segment size registers that exist, and the default segment limit.
	localparam int SIZE_REGS            = 4;
	localparam int DEFAULT_MAX_SEGMENTS = 4;

	// Decoupling queue between the front and the back.
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_W = 1;
	localparam int QUEUE_CNT_W = 2;

	typedef enum logic [TYPE_W-1:0] {
		REQ_READ_AT   = 3'd0,
		REQ_WRITE_AT  = 3'd1,
		REQ_READ_CUR  = 3'd2,
		REQ_WRITE_CUR = 3'd3,
		REQ_SET_POS   = 3'd4
	} req_type_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SEGMENT_COUNT = 3'd0,
		CFG_SEG_SIZE_0    = 3'd1,
		CFG_SEG_SIZE_1    = 3'd2,
		CFG_SEG_SIZE_2    = 3'd3,
		CFG_SEG_SIZE_3    = 3'd4
	} cfg_reg_t;

	// One classified request, handed from the front to the back.
	typedef struct packed {
		logic             ack;
		logic             wr;
		logic [POS_W-1:0] pos;
		logic [LEN_W-1:0] len;
	} job_t;

endpackage

@@ rtl/core/ssas_channels.sv @@
`timescale 1ns / 1ps

// Request channel.
interface ssas_req_if;
	logic                       valid;
	logic                       ready;
	logic [ssas_pkg::TYPE_W-1:0] req_type;
	logic [ssas_pkg::POS_W-1:0]  position;
	logic [ssas_pkg::LEN_W-1:0]  request_length;

	modport source (output valid, output req_type, output position, output request_length,
		input ready);
	modport sink (input valid, input req_type, input position, input request_length,
		output ready);
endinterface

// Piece channel.
interface ssas_piece_if;
	logic                       valid;
	logic                       ready;
	logic [ssas_pkg::SEG_W-1:0] segment_index;
	logic [ssas_pkg::POS_W-1:0] local_offset;
	logic [ssas_pkg::LEN_W-1:0] piece_length;
	logic [ssas_pkg::LEN_W-1:0] buffer_offset;
	logic                       is_write;
	logic                       last_piece;

	modport source (output valid, output segment_index, output local_offset,
		output piece_length, output buffer_offset, output is_write, output last_piece,
		input ready);
	modport sink (input valid, input segment_index, input local_offset,
		input piece_length, input buffer_offset, input is_write, input last_piece,
		output ready);
endinterface

// Configuration write channel.
interface ssas_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [ssas_pkg::CFG_IDX_W-1:0] index;
	logic [ssas_pkg::POS_W-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/ssas_front.sv @@
`timescale 1ns / 1ps

module ssas_front import ssas_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	ssas_req_if.sink req,
	output logic   push_valid,
	input  logic   push_ready,
	output job_t   push_job
);

	logic [POS_W-1:0] cur_pos_q;
	req_type_t        kind;
	logic             known;
	logic             accepted;

	assign kind     = req_type_t'(req.req_type);
	assign accepted = req.valid && req.ready;

	// Classify the request and resolve its start position.
	always_comb begin
		push_job.ack = 1'b0;
		push_job.wr  = 1'b0;
		push_job.pos = req.position;
		push_job.len = req.request_length;
		known        = 1'b1;
		case (kind)
			REQ_READ_AT: begin
			end
			REQ_WRITE_AT: begin
				push_job.wr = 1'b1;
			end
			REQ_READ_CUR: begin
				push_job.pos = cur_pos_q;
			end
			REQ_WRITE_CUR: begin
				push_job.pos = cur_pos_q;
				push_job.wr  = 1'b1;
			end
			REQ_SET_POS: begin
				push_job.ack = 1'b1;
			end
			default: begin
				known = 1'b0;
			end
		endcase
	end

	// Unknown request types are taken and dropped.
	assign req.ready  = push_ready;
	assign push_valid = req.valid && known;

	// Current position: loaded by set-position, advanced by sequential requests.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_pos_q <= '0;
		end else if (accepted) begin
			case (kind)
				REQ_SET_POS: begin
					cur_pos_q <= req.position;
				end
				REQ_READ_CUR, REQ_WRITE_CUR: begin
					cur_pos_q <= cur_pos_q + {{(POS_W-LEN_W){1'b0}}, req.request_length};
				end
				default: begin
					cur_pos_q <= cur_pos_q;
				end
			endcase
		end
	end

endmodule

@@ rtl/core/ssas_queue.sv @@
`timescale 1ns / 1ps

module ssas_queue import ssas_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  job_t push_job,
	output logic pop_valid,
	input  logic pop_ready,
	output job_t pop_job
);

	job_t                   entry_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_CNT_W-1:0] count_q;
	logic                   push;
	logic                   pop;

	assign push_ready = count_q != QUEUE_CNT_W'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_job    = entry_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/core/ssas_back.sv @@
`timescale 1ns / 1ps

module ssas_back import ssas_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pop_valid,
	output logic             pop_ready,
	input  job_t             pop_job,
	input  logic [POS_W-1:0] seg_size [SIZE_REGS],
	input  logic [SEG_W-1:0] last_seg,
	ssas_piece_if.source     piece
);

	// Walk state.
	logic             busy_q;
	logic             ack_q;
	logic             wr_q;
	logic [SEG_W-1:0] seg_q;
	logic [POS_W-1:0] pos_q;
	logic [LEN_W-1:0] len_q;
	logic [LEN_W-1:0] buf_q;

	// Output register.
	logic             out_valid_q;
	logic [SEG_W-1:0] out_seg_q;
	logic [POS_W-1:0] out_off_q;
	logic [LEN_W-1:0] out_len_q;
	logic [LEN_W-1:0] out_buf_q;
	logic             out_wr_q;
	logic             out_last_q;

	logic [POS_W-1:0] size;
	logic [POS_W-1:0] room;
	logic [LEN_W-1:0] part;
	logic             is_last;
	logic             holds;
	logic             fits;
	logic             emit;
	logic             final_piece;
	logic             out_free;
	logic             step;
	logic             done;
	logic             load;

	// Examine one segment per cycle; a step that emits a piece waits for a free output register.
	always_comb begin
		size    = seg_size[seg_q];
		room    = size - pos_q;
		part    = room[LEN_W-1:0];
		is_last = seg_q == last_seg;
		holds   = pos_q < size;
		fits    = {{(POS_W-LEN_W){1'b0}}, len_q} <= room;
		if (ack_q) begin
			emit        = 1'b1;
			final_piece = 1'b1;
		end else if (is_last || holds) begin
			emit        = 1'b1;
			final_piece = is_last || fits;
		end else begin
			emit        = 1'b0;
			final_piece = 1'b0;
		end
	end

	assign out_free  = !out_valid_q || piece.ready;
	assign step      = busy_q && (!emit || out_free);
	assign done      = step && final_piece;
	assign pop_ready = !busy_q || done;
	assign load      = pop_valid && pop_ready;

	// Walk registers: load a job, then advance segment by segment.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (load) begin
			busy_q <= 1'b1;
		end else if (done) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ack_q <= pop_job.ack;
			wr_q  <= pop_job.wr;
			seg_q <= '0;
			pos_q <= pop_job.pos;
			len_q <= pop_job.len;
			buf_q <= '0;
		end else if (step && !final_piece) begin
			seg_q <= seg_q + 1'b1;
			if (emit) begin
				pos_q <= '0;
				buf_q <= buf_q + part;
				len_q <= len_q - part;
			end else begin
				pos_q <= pos_q - size;
			end
		end
	end

	// Output register: a finished piece waits here while the walk goes on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && emit) begin
			out_valid_q <= 1'b1;
		end else if (piece.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && emit) begin
			out_seg_q  <= ack_q ? '0 : seg_q;
			out_off_q  <= ack_q ? '0 : pos_q;
			out_len_q  <= ack_q ? '0 : (final_piece ? len_q : part);
			out_buf_q  <= ack_q ? '0 : buf_q;
			out_wr_q   <= ack_q ? 1'b0 : wr_q;
			out_last_q <= final_piece;
		end
	end

	assign piece.valid         = out_valid_q;
	assign piece.segment_index = out_seg_q;
	assign piece.local_offset  = out_off_q;
	assign piece.piece_length  = out_len_q;
	assign piece.buffer_offset = out_buf_q;
	assign piece.is_write      = out_wr_q;
	assign piece.last_piece    = out_last_q;

	// A piece that is not the last one carries bytes and lies before the last segment.
	a_split_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_last_q |-> out_len_q != '0)
		else $error("split piece with zero length");

	a_split_segment: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_last_q |-> out_seg_q < last_seg)
		else $error("split piece in or beyond the last segment");

	// The walk never passes the last segment in use.
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !ack_q |-> seg_q <= last_seg)
		else $error("walk passed the last segment");

	// A job taken from the queue starts a walk.
	a_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> busy_q)
		else $error("job taken but walk not started");

endmodule

@@ rtl/core/segmented_span_address_splitter_top.sv @@
`timescale 1ns / 1ps

// Splits a read or write request on a space of up to four concatenated segments into one
// piece beat per segment touched; the last segment in use takes all bytes beyond the others.
// The front takes one request beat per cycle while the two-entry job queue has room; the back
// walks the segment sizes one segment per cycle, from segment 0 up to the one where the request
// ends, and answers a set-position request with a single acknowledge piece. A step that emits a
// piece waits until the piece output register is free, so a stalled piece channel stretches a
// request by the stall. Configuration beats are always taken.
module segmented_span_address_splitter_top import ssas_pkg::*; #(
	parameter int MAX_SEGMENTS = DEFAULT_MAX_SEGMENTS
) (
	input  logic     clk,
	input  logic     arst_n,
	ssas_cfg_if.sink cfg,
	ssas_req_if.sink req,
	ssas_piece_if.source piece
);

	localparam int SEG_LIMIT = (MAX_SEGMENTS < SIZE_REGS) ? MAX_SEGMENTS : SIZE_REGS;

	logic [CNT_W-1:0] segment_count_q;
	logic [POS_W-1:0] seg_size_q [SIZE_REGS];
	logic [SEG_W-1:0] last_seg;
	logic             push_valid;
	logic             push_ready;
	job_t             push_job;
	logic             pop_valid;
	logic             pop_ready;
	job_t             pop_job;

	assign cfg.ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			segment_count_q <= CNT_W'(1);
			for (int i = 0; i < SIZE_REGS; i++) begin
				seg_size_q[i] <= '0;
			end
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.index))
				CFG_SEGMENT_COUNT: segment_count_q <= cfg.data[CNT_W-1:0];
				CFG_SEG_SIZE_0:    seg_size_q[0]   <= cfg.data;
				CFG_SEG_SIZE_1:    seg_size_q[1]   <= cfg.data;
				CFG_SEG_SIZE_2:    seg_size_q[2]   <= cfg.data;
				CFG_SEG_SIZE_3:    seg_size_q[3]   <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	// Last segment in use: a count of zero means one, a large count saturates.
	always_comb begin
		if (segment_count_q == '0) begin
			last_seg = '0;
		end else if (segment_count_q > CNT_W'(SEG_LIMIT)) begin
			last_seg = SEG_W'(SEG_LIMIT - 1);
		end else begin
			last_seg = SEG_W'(segment_count_q - 1'b1);
		end
	end

	ssas_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job)
	);

	ssas_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_job    (pop_job)
	);

	ssas_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_job   (pop_job),
		.seg_size  (seg_size_q),
		.last_seg  (last_seg),
		.piece     (piece)
	);

endmodule
